/* rtl/core/spi_master_mode3_core_defines.svh */
// Assertion macros used by the SPI master core back end.
`ifndef SPI_MASTER_MODE3_CORE_DEFINES_SVH
`define SPI_MASTER_MODE3_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SPIMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define SPIMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SPIMC_ASSERT(lbl, prop, msg)
`define SPIMC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/core/spimc_pkg.sv */
// Types and constants shared by the SPI master core.
package spimc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 5;

  // request codes as seen on the input port
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_SELECT  = 3'd1;
  localparam logic [2:0] REQ_PAUSE   = 3'd2;
  localparam logic [2:0] REQ_RELEASE = 3'd3;
  localparam logic [2:0] REQ_START8  = 3'd4;
  localparam logic [2:0] REQ_START32 = 3'd5;

  // top bit position of each transfer size
  localparam logic [IDX_W-1:0] TOP_BIT8  = 5'd7;
  localparam logic [IDX_W-1:0] TOP_BIT32 = 5'd31;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_SELECT,
    OP_PAUSE,
    OP_RELEASE,
    OP_START8,
    OP_START32,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] word;
    logic              miso;
  } q_entry_t;

endpackage

/* rtl/core/spimc_front.sv */
// Front end: decode requests and hold them in a two-entry queue.
module spimc_front
  import spimc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic [WORD_W-1:0] in_tx_word,
  input  logic              in_miso_level,
  output logic              q_valid,
  input  logic              q_pop,
  output q_entry_t          q_head
);

  q_entry_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  q_entry_t   dec;

  // classify the request; mask the word for byte transfers
  always_comb begin
    dec.word = in_tx_word;
    dec.miso = in_miso_level;
    case (in_req_type)
      REQ_TICK:    dec.op = OP_TICK;
      REQ_SELECT:  dec.op = OP_SELECT;
      REQ_PAUSE:   dec.op = OP_PAUSE;
      REQ_RELEASE: dec.op = OP_RELEASE;
      REQ_START8: begin
        dec.op   = OP_START8;
        dec.word = {{(WORD_W-8){1'b0}}, in_tx_word[7:0]};
      end
      REQ_START32: dec.op = OP_START32;
      default:     dec.op = OP_NOP;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_head   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

/* rtl/core/spimc_back.sv */
// Back end: serial engine state and the registered result word.
`include "spi_master_mode3_core_defines.svh"

module spimc_back
  import spimc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  q_entry_t          q_head,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_sck_level,
  output logic              out_mosi_level,
  output logic              out_cs_level,
  output logic              out_busy_res,
  output logic              out_done_res,
  output logic [WORD_W-1:0] out_rx_word
);

  logic [WORD_W-1:0] send_r, send_nxt;
  logic [WORD_W-1:0] recv_r, recv_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              high_r, high_nxt;
  logic              active_r, active_nxt;
  logic              sel_r, sel_nxt;
  logic              pend_r, pend_nxt;
  logic              sck_r, sck_nxt;
  logic              mosi_r, mosi_nxt;
  logic              done_nxt;
  logic [WORD_W-1:0] rx_nxt;

  logic              ovalid_r;
  logic              odone_r;
  logic [WORD_W-1:0] orx_r;

  assign q_pop = q_valid && (!ovalid_r || !out_stall);

  always_comb begin
    send_nxt   = send_r;
    recv_nxt   = recv_r;
    idx_nxt    = idx_r;
    high_nxt   = high_r;
    active_nxt = active_r;
    sel_nxt    = pend_r ? 1'b0 : sel_r;
    pend_nxt   = 1'b0;
    sck_nxt    = sck_r;
    mosi_nxt   = mosi_r;
    done_nxt   = 1'b0;
    rx_nxt     = '0;
    if (q_head.op == OP_TICK) begin
      if (active_r) begin
        if (!high_r) begin
          sck_nxt  = 1'b0;
          mosi_nxt = send_r[idx_r];
          high_nxt = 1'b1;
        end else begin
          sck_nxt         = 1'b1;
          recv_nxt[idx_r] = q_head.miso;
          high_nxt        = 1'b0;
          if (idx_r == '0) begin
            active_nxt = 1'b0;
            done_nxt   = 1'b1;
            rx_nxt     = recv_nxt;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
    end else if (!active_r) begin
      case (q_head.op)
        OP_SELECT: begin
          sel_nxt = 1'b0;
          sck_nxt = 1'b1;
        end
        OP_PAUSE: begin
          sel_nxt  = 1'b1;
          pend_nxt = 1'b1;
        end
        OP_RELEASE: sel_nxt = 1'b1;
        OP_START8, OP_START32: begin
          send_nxt   = q_head.word;
          recv_nxt   = '0;
          idx_nxt    = (q_head.op == OP_START8) ? TOP_BIT8 : TOP_BIT32;
          high_nxt   = 1'b0;
          active_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_r   <= '0;
      recv_r   <= '0;
      idx_r    <= '0;
      high_r   <= 1'b0;
      active_r <= 1'b0;
      sel_r    <= 1'b1;
      pend_r   <= 1'b0;
      sck_r    <= 1'b1;
      mosi_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        send_r   <= send_nxt;
        recv_r   <= recv_nxt;
        idx_r    <= idx_nxt;
        high_r   <= high_nxt;
        active_r <= active_nxt;
        sel_r    <= sel_nxt;
        pend_r   <= pend_nxt;
        sck_r    <= sck_nxt;
        mosi_r   <= mosi_nxt;
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // result payload; pin levels come straight from the engine state
  always_ff @(posedge clk) begin
    if (q_pop) begin
      odone_r <= done_nxt;
      orx_r   <= rx_nxt;
    end
  end

  assign out_valid      = ovalid_r;
  assign out_sck_level  = sck_r;
  assign out_mosi_level = mosi_r;
  assign out_cs_level   = sel_r;
  assign out_busy_res   = active_r;
  assign out_done_res   = odone_r;
  assign out_rx_word    = orx_r;

  `SPIMC_ASSERT(a_high_needs_active, high_r |-> active_r, "high phase outside transfer")
  `SPIMC_ASSERT(a_done_not_busy, (ovalid_r && odone_r) |-> !active_r, "done while busy")
  `SPIMC_ASSERT(a_rx_zero_unless_done, (ovalid_r && !odone_r) |-> (orx_r == '0),
                "rx word without done")
  `SPIMC_ASSERT(a_pend_deselects, pend_r |-> (sel_r && !active_r), "pause state corrupt")

endmodule

/* rtl/core/spi_master_mode3_core.sv */
// Top level of the SPI master core, mode 3, MSB first.
// SPI master, mode 3 (SCK idles high), MSB first, 8-bit or 32-bit words.
// Each input word is a half-bit tick or a command (select, pause, release,
// start 8-bit, start 32-bit); every accepted word yields exactly one result
// word carrying the SCK, MOSI and CS pin levels, busy, done and the received
// word (zero unless done). A transfer takes two ticks per bit: the low phase
// drives MOSI, the high phase samples MISO. Commands other than ticks are
// ignored while busy. Throughput is one word per clock while out_stall is
// low: the front decodes into a two-entry queue, the back updates the serial
// engine and loads a result register. The accepting edge writes the queue;
// the entry is popped into the result register, raising out_valid, once that
// register is empty or being taken; in_stall rises only when the queue is
// full.
module spi_master_mode3_core
  import spimc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic [WORD_W-1:0] in_tx_word,
  input  logic              in_miso_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_sck_level,
  output logic              out_mosi_level,
  output logic              out_cs_level,
  output logic              out_busy_res,
  output logic              out_done_res,
  output logic [WORD_W-1:0] out_rx_word
);

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_head;

  // decode and buffer incoming words
  spimc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_tx_word    (in_tx_word),
    .in_miso_level (in_miso_level),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_head        (q_head)
  );

  // run the serial engine and hold the result until taken
  spimc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_head         (q_head),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sck_level  (out_sck_level),
    .out_mosi_level (out_mosi_level),
    .out_cs_level   (out_cs_level),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_rx_word    (out_rx_word)
  );

endmodule

/* tb/sv/spi_pin_checker.sv */
// Pin-level predictor and result comparator for the mode 3 SPI master core.
module spi_pin_checker
  import spimc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic [WORD_W-1:0] in_tx_word,
  input  logic              in_miso_level,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_sck_level,
  input  logic              out_mosi_level,
  input  logic              out_cs_level,
  input  logic              out_busy_res,
  input  logic              out_done_res,
  input  logic [WORD_W-1:0] out_rx_word,
  output int unsigned       fail_cnt,
  output int unsigned       pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              sck;
    logic              mosi;
    logic              cs;
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] rx;
  } pin_result_t;

  // serial engine as the core should hold it
  logic [WORD_W-1:0] send_sr;
  logic [WORD_W-1:0] recv_sr;
  logic [IDX_W-1:0]  bit_pos;
  logic              hi_phase;
  logic              xfer_on;
  logic              cs_q;
  logic              pause_q;
  logic              sck_q;
  logic              mosi_q;

  pin_result_t pin_results_q[$];
  int unsigned fails;

  initial begin
    fail_cnt    = 0;
    pending_cnt = 0;
    fails       = 0;
  end

  function automatic pin_result_t predict_pins(logic [2:0] req, logic [WORD_W-1:0] word,
                                               logic miso);
    pin_result_t r;
    r = '0;
    // a pause lasts one word: select drops again before this word is handled
    if (pause_q) begin
      cs_q    = 1'b0;
      pause_q = 1'b0;
    end
    if (req == REQ_TICK) begin
      if (xfer_on) begin
        if (!hi_phase) begin
          sck_q    = 1'b0;
          mosi_q   = send_sr[bit_pos];
          hi_phase = 1'b1;
        end else begin
          sck_q            = 1'b1;
          recv_sr[bit_pos] = miso;
          hi_phase         = 1'b0;
          if (bit_pos == '0) begin
            xfer_on = 1'b0;
            r.done  = 1'b1;
            r.rx    = recv_sr;
          end else begin
            bit_pos = bit_pos - 1'b1;
          end
        end
      end
    end else if (!xfer_on) begin
      case (req)
        REQ_SELECT: begin
          cs_q  = 1'b0;
          sck_q = 1'b1;
        end
        REQ_PAUSE: begin
          cs_q    = 1'b1;
          pause_q = 1'b1;
        end
        REQ_RELEASE: cs_q = 1'b1;
        REQ_START8, REQ_START32: begin
          send_sr  = (req == REQ_START8) ? {24'h0, word[7:0]} : word;
          bit_pos  = (req == REQ_START8) ? TOP_BIT8 : TOP_BIT32;
          recv_sr  = '0;
          hi_phase = 1'b0;
          xfer_on  = 1'b1;
        end
        default: ;
      endcase
    end
    r.sck  = sck_q;
    r.mosi = mosi_q;
    r.cs   = cs_q;
    r.busy = xfer_on;
    return r;
  endfunction

  always @(posedge clk) begin
    pin_result_t exp_r;
    if (!rst_n) begin
      send_sr  = '0;
      recv_sr  = '0;
      bit_pos  = '0;
      hi_phase = 1'b0;
      xfer_on  = 1'b0;
      cs_q     = 1'b1;
      pause_q  = 1'b0;
      sck_q    = 1'b1;
      mosi_q   = 1'b0;
      pin_results_q.delete();
    end else begin
      if (in_valid && !in_stall)
        pin_results_q.push_back(predict_pins(in_req_type, in_tx_word, in_miso_level));
      if (out_valid && !out_stall) begin
        if (pin_results_q.size() == 0) begin
          $error("result word with no prediction pending");
          fails++;
        end else begin
          exp_r = pin_results_q.pop_front();
          if (out_sck_level !== exp_r.sck) begin
            $error("sck_level: expected %0b, got %0b", exp_r.sck, out_sck_level);
            fails++;
          end
          if (out_mosi_level !== exp_r.mosi) begin
            $error("mosi_level: expected %0b, got %0b", exp_r.mosi, out_mosi_level);
            fails++;
          end
          if (out_cs_level !== exp_r.cs) begin
            $error("cs_level: expected %0b, got %0b", exp_r.cs, out_cs_level);
            fails++;
          end
          if (out_busy_res !== exp_r.busy) begin
            $error("busy_res: expected %0b, got %0b", exp_r.busy, out_busy_res);
            fails++;
          end
          if (out_done_res !== exp_r.done) begin
            $error("done_res: expected %0b, got %0b", exp_r.done, out_done_res);
            fails++;
          end
          if (out_rx_word !== exp_r.rx) begin
            $error("rx_word: expected %08h, got %08h", exp_r.rx, out_rx_word);
            fails++;
          end
        end
      end
    end
    fail_cnt    <= fails;
    pending_cnt <= pin_results_q.size();
  end

endmodule

/* tb/sv/tb_spi_master_mode3_core.sv */
// Stimulus, handshake pacing and verdict for the mode 3 SPI master core.
module tb_spi_master_mode3_core;
  import spimc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // codes the core must treat as no-ops
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;

  localparam int unsigned ITEM_TARGET = 1500;
  localparam int unsigned CALM_FROM   = 1350;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_req_type = REQ_TICK;
  logic [WORD_W-1:0] in_tx_word = '0;
  logic              in_miso_level = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_sck_level;
  logic              out_mosi_level;
  logic              out_cs_level;
  logic              out_busy_res;
  logic              out_done_res;
  logic [WORD_W-1:0] out_rx_word;

  int unsigned fail_cnt;
  int unsigned pending_cnt;

  // pacing knobs: gap_pct is the chance of an input gap before a word,
  // calm turns off all idling for the last stretch of the run
  int unsigned gap_pct = 0;
  bit          calm = 1'b0;
  int unsigned item_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spi_master_mode3_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_tx_word     (in_tx_word),
    .in_miso_level  (in_miso_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sck_level  (out_sck_level),
    .out_mosi_level (out_mosi_level),
    .out_cs_level   (out_cs_level),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_rx_word    (out_rx_word)
  );

  spi_pin_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_tx_word     (in_tx_word),
    .in_miso_level  (in_miso_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sck_level  (out_sck_level),
    .out_mosi_level (out_mosi_level),
    .out_cs_level   (out_cs_level),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_rx_word    (out_rx_word),
    .fail_cnt       (fail_cnt),
    .pending_cnt    (pending_cnt)
  );

  // Result-side backpressure: random free stretches alternate with random
  // stall bursts. Drop all stalling once calm is set.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 40);
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one word and hold it until the core takes it. An optional idle gap
  // goes in front of it.
  task automatic send_item(input logic [2:0] req, input logic [WORD_W-1:0] word,
                           input logic miso);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_tx_word    <= word;
    in_miso_level <= miso;
    do @(posedge clk); while (in_stall);
    item_cnt++;
  endtask

  // Clock nbits bits out, MSB first: two ticks per bit. The high-phase tick
  // carries the MISO bit for that position, so the word that comes back with
  // done equals miso_bits. Commands sprinkled in while busy must be ignored.
  task automatic clock_bits(input int nbits, input logic [WORD_W-1:0] miso_bits,
                            input int unsigned noise_pct);
    for (int i = nbits - 1; i >= 0; i--) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(3'($urandom_range(1, 7)), $urandom, 1'($urandom_range(0, 1)));
      send_item(REQ_TICK, $urandom, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < noise_pct)
        send_item(3'($urandom_range(1, 7)), $urandom, 1'($urandom_range(0, 1)));
      send_item(REQ_TICK, $urandom, miso_bits[i]);
    end
  endtask

  task automatic run_transfer(input bit wide, input logic [WORD_W-1:0] word,
                              input logic [WORD_W-1:0] miso_bits,
                              input int unsigned noise_pct);
    send_item(wide ? REQ_START32 : REQ_START8, word, 1'($urandom_range(0, 1)));
    clock_bits(wide ? 32 : 8, miso_bits, noise_pct);
  endtask

  // Hold the sender until every predicted result has come back. The first
  // edge lets the checker see the last accepted word.
  task automatic wait_pins_settled();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned pick;
    bit          drained_mid;
    drained_mid = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: idle tick, spare code, select / pause / release, an
    // 8-bit transfer with every command thrown at it while busy, a start
    // with chip select high, and both data extremes.
    gap_pct = 10;
    send_item(REQ_TICK, 32'hFFFF_FFFF, 1'b1);
    send_item(REQ_SPARE7, 32'hFFFF_FFFF, 1'b1);
    send_item(REQ_SELECT, '0, 1'b0);
    send_item(REQ_PAUSE, '0, 1'b0);
    send_item(REQ_TICK, '0, 1'b0);
    send_item(REQ_PAUSE, '0, 1'b1);
    send_item(REQ_RELEASE, '0, 1'b1);
    send_item(REQ_SELECT, '0, 1'b0);
    send_item(REQ_START8, 32'hFFFF_FFA5, 1'b0);
    send_item(REQ_SELECT, '0, 1'b1);
    send_item(REQ_PAUSE, '0, 1'b1);
    send_item(REQ_RELEASE, '0, 1'b1);
    send_item(REQ_START8, '0, 1'b1);
    send_item(REQ_START32, '0, 1'b1);
    send_item(REQ_SPARE6, '0, 1'b1);
    clock_bits(8, 32'h0000_00FF, 0);
    send_item(REQ_SPARE6, '0, 1'b0);
    send_item(REQ_RELEASE, '0, 1'b0);
    run_transfer(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 0);
    run_transfer(1'b0, 32'h0000_0000, 32'h0000_00FF, 0);

    // Pressure point: let the core drain completely before the random part.
    wait_pins_settled();

    // Random part: mostly well-formed select / transfer / release sequences
    // with random content, some noise words in between.
    while (item_cnt < ITEM_TARGET) begin
      calm = (item_cnt >= CALM_FROM);
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        if ($urandom_range(0, 1) == 1) begin
          send_item(REQ_SELECT, $urandom, 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 4) == 0) begin
          send_item(REQ_PAUSE, $urandom, 1'($urandom_range(0, 1)));
        end
        case ($urandom_range(0, 19))
          0:       run_transfer(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10);
          1:       run_transfer(1'b1, 32'h0000_0000, 32'h0000_0000, 10);
          2, 3, 4: run_transfer(1'b1, $urandom, $urandom, 10);
          default: run_transfer(1'b0, $urandom, $urandom, 15);
        endcase
        if ($urandom_range(0, 2) == 0) begin
          send_item(REQ_RELEASE, $urandom, 1'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(3'($urandom_range(0, 7)), $urandom, 1'($urandom_range(0, 1)));
        end
      end
      if (!drained_mid && item_cnt >= ITEM_TARGET / 2) begin
        drained_mid = 1'b1;
        wait_pins_settled();
      end
    end

    wait_pins_settled();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
